>>> hdl/ata_pio_transfer_sequencer_assert.svh
// ----------------------------------------------------------------------------
// ATA PIO transfer sequencer assertion macros
// Shorthand for concurrent checks clocked by clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_TRANSFER_SEQUENCER_ASSERT_SVH
`define ATA_PIO_TRANSFER_SEQUENCER_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent
`define ATAPIO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent
`define ATAPIO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/atapio_pkg.sv
// ----------------------------------------------------------------------------
// atapio_pkg
// Shared types, codes and constants of the ATA PIO transfer sequencer.
// ----------------------------------------------------------------------------
package atapio_pkg;

  // Sector count width used from a start request
  localparam int COUNT_BITS    = 16;
  localparam int LBA_W         = 28;
  localparam int CHUNK_SECTORS = 256;
  localparam int CHUNK_W       = $clog2(CHUNK_SECTORS) + 1;
  localparam int WORD_SHIFT    = 8;
  localparam int WORDS_W       = CHUNK_W + WORD_SHIFT;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [LBA_W-1:0] HIGHEST_LBA_RESET = 28'd163839;

  // Input item kinds
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_STATUS = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_REG    = 3'd0;
  localparam logic [2:0] ACT_STATUS = 3'd1;
  localparam logic [2:0] ACT_WRDATA = 3'd2;
  localparam logic [2:0] ACT_TOHOST = 3'd3;
  localparam logic [2:0] ACT_DONE   = 3'd4;
  localparam logic [2:0] ACT_FAIL   = 3'd5;

  // Failure reasons
  localparam logic [2:0] RSN_NONE       = 3'd0;
  localparam logic [2:0] RSN_LBA        = 3'd1;
  localparam logic [2:0] RSN_ZERO       = 3'd2;
  localparam logic [2:0] RSN_NODRQ      = 3'd3;
  localparam logic [2:0] RSN_UNEXPECTED = 3'd4;

  // Task-file register offsets
  localparam logic [2:0] PORT_DATA    = 3'd0;
  localparam logic [2:0] PORT_COUNT   = 3'd2;
  localparam logic [2:0] PORT_LBA0    = 3'd3;
  localparam logic [2:0] PORT_LBA1    = 3'd4;
  localparam logic [2:0] PORT_LBA2    = 3'd5;
  localparam logic [2:0] PORT_DEVICE  = 3'd6;
  localparam logic [2:0] PORT_COMMAND = 3'd7;

  // Register byte values
  localparam logic [7:0] DEV_BASE  = 8'hA0 | 8'h40;
  localparam logic [7:0] DEV_SLAVE = 8'h10;
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam int STATUS_BSY_BIT = 7;
  localparam int STATUS_DRQ_BIT = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STATUS,
    PH_DATA
  } phase_t;

  // What follows the optional select and word of a job
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_CHUNK,
    TAIL_STATUS,
    TAIL_DONE,
    TAIL_FAIL
  } tail_t;

  // Result steps of the back end
  typedef enum logic [3:0] {
    ST_SEL,
    ST_WORD,
    ST_CNT,
    ST_L0,
    ST_L1,
    ST_L2,
    ST_DEV,
    ST_CMD,
    ST_STAT,
    ST_DONE,
    ST_FAIL,
    ST_END
  } step_t;

  // One classified item, as the back end expands it
  typedef struct packed {
    logic               has_sel;
    logic               has_word;
    tail_t              tail;
    logic [2:0]         reason;
    logic               direction;
    logic               drive;
    logic [15:0]        word;
    logic [LBA_W-1:0]   lba;
    logic [7:0]         count_byte;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

>>> hdl/atapio_front.sv
// ----------------------------------------------------------------------------
// atapio_front
// Accepts items, tracks transfer state, makes a job of each but a DRQ status.
// ----------------------------------------------------------------------------
module atapio_front import atapio_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       mode,
  input  logic             is_write,
  input  logic             drive,
  input  logic [LBA_W-1:0] lba,
  input  logic [15:0]      sector_count,
  input  logic [7:0]       status_byte,
  input  logic [15:0]      data_word,
  input  logic             cfg_write,
  input  logic [LBA_W-1:0] cfg_value,
  output logic             push,
  output job_t             push_job
);

  phase_t                phase, phase_next;
  logic                  direction;
  logic                  drive_sel;
  logic [LBA_W-1:0]      next_lba;
  logic                  lba_over;
  logic [COUNT_BITS-1:0] sectors_left;
  logic [WORDS_W-1:0]    words_left;
  logic [LBA_W-1:0]      highest_lba;

  logic [COUNT_BITS-1:0] count_in;
  logic [LBA_W-1:0]      base_lba;
  logic                  base_over;
  logic [COUNT_BITS-1:0] base_sectors;
  logic [CHUNK_W-1:0]    chunk;
  logic [LBA_W:0]        lba_sum;
  logic                  chunk_fail;
  logic [WORDS_W-1:0]    words_after;
  logic                  is_start, is_status, is_data;
  logic                  chunk_end, xfer_done, issue_ok;
  logic                  busy, drq;

  assign count_in  = COUNT_BITS'(sector_count);
  assign is_start  = (mode == MODE_START)  && (phase == PH_IDLE);
  assign is_status = (mode == MODE_STATUS) && (phase == PH_STATUS);
  assign is_data   = (mode == MODE_DATA)   && (phase == PH_DATA);
  assign busy      = status_byte[STATUS_BSY_BIT];
  assign drq       = status_byte[STATUS_DRQ_BIT];

  // Select the chunk source: the request itself, or the running transfer
  always_comb begin
    if (phase == PH_IDLE) begin
      base_lba     = lba;
      base_over    = 1'b0;
      base_sectors = count_in;
    end else begin
      base_lba     = next_lba;
      base_over    = lba_over;
      base_sectors = sectors_left;
    end
  end

  // Size the chunk and check its start address
  assign chunk = (base_sectors >= COUNT_BITS'(CHUNK_SECTORS)) ? CHUNK_W'(CHUNK_SECTORS)
                                                               : CHUNK_W'(base_sectors);
  assign lba_sum    = {1'b0, base_lba} + (LBA_W + 1)'(chunk);
  assign chunk_fail = base_over || (base_lba > highest_lba);

  // Count down the words of the current chunk
  assign words_after = (words_left != '0) ? words_left - WORDS_W'(1) : '0;
  assign chunk_end   = is_data && (words_after == '0) && (sectors_left != '0);
  assign xfer_done   = is_data && (words_after == '0) && (sectors_left == '0);
  assign issue_ok    = (is_start && !chunk_fail && (count_in != '0)) ||
                       (chunk_end && !chunk_fail);

  // Next phase
  always_comb begin
    phase_next = PH_IDLE;
    priority if (is_start) begin
      phase_next = (chunk_fail || (count_in == '0)) ? PH_IDLE : PH_STATUS;
    end else if (is_status) begin
      priority if (busy) phase_next = PH_STATUS;
      else if (!drq)     phase_next = PH_IDLE;
      else               phase_next = PH_DATA;
    end else if (is_data) begin
      priority if (xfer_done) phase_next = PH_IDLE;
      else if (chunk_end)     phase_next = chunk_fail ? PH_IDLE : PH_STATUS;
      else                    phase_next = PH_DATA;
    end else begin
      phase_next = PH_IDLE;
    end
  end

  // Build the job for the back end
  always_comb begin
    push                = 1'b0;
    push_job            = '0;
    push_job.tail       = TAIL_NONE;
    push_job.reason     = RSN_NONE;
    push_job.direction  = is_start ? is_write : direction;
    push_job.drive      = is_start ? drive : drive_sel;
    push_job.word       = data_word;
    push_job.lba        = base_lba;
    push_job.count_byte = chunk[7:0];
    priority if (is_start) begin
      push = accept;
      priority if (chunk_fail) begin
        push_job.tail   = TAIL_FAIL;
        push_job.reason = RSN_LBA;
      end else if (count_in == '0) begin
        push_job.tail   = TAIL_FAIL;
        push_job.reason = RSN_ZERO;
      end else begin
        push_job.has_sel = 1'b1;
        push_job.tail    = TAIL_CHUNK;
      end
    end else if (is_status) begin
      priority if (busy) begin
        push          = accept;
        push_job.tail = TAIL_STATUS;
      end else if (!drq) begin
        push            = accept;
        push_job.tail   = TAIL_FAIL;
        push_job.reason = RSN_NODRQ;
      end else begin
        push = 1'b0;
      end
    end else if (is_data) begin
      push              = accept;
      push_job.has_word = 1'b1;
      priority if (xfer_done) begin
        push_job.tail = TAIL_DONE;
      end else if (chunk_end) begin
        if (chunk_fail) begin
          push_job.tail   = TAIL_FAIL;
          push_job.reason = RSN_LBA;
        end else begin
          push_job.tail = TAIL_CHUNK;
        end
      end else begin
        push_job.tail = TAIL_NONE;
      end
    end else begin
      push            = accept;
      push_job.tail   = TAIL_FAIL;
      push_job.reason = RSN_UNEXPECTED;
    end
  end

  // Update transfer state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      direction    <= 1'b0;
      drive_sel    <= 1'b0;
      next_lba     <= '0;
      lba_over     <= 1'b0;
      sectors_left <= '0;
      words_left   <= '0;
      highest_lba  <= HIGHEST_LBA_RESET;
    end else begin
      if (cfg_write) begin
        highest_lba <= cfg_value;
      end
      if (accept) begin
        phase <= phase_next;
        if (is_start && issue_ok) begin
          direction <= is_write;
          drive_sel <= drive;
        end
        // Load a new chunk, or count down the current one
        if (issue_ok) begin
          next_lba     <= lba_sum[LBA_W-1:0];
          lba_over     <= lba_sum[LBA_W];
          sectors_left <= base_sectors - COUNT_BITS'(chunk);
          words_left   <= {chunk, WORD_SHIFT'(0)};
        end else if (is_data) begin
          words_left <= words_after;
        end
      end
    end
  end

endmodule

>>> hdl/atapio_queue.sv
// ----------------------------------------------------------------------------
// atapio_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module atapio_queue import atapio_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  job_t  push_job,
  input  logic  pop,
  output logic  full,
  output head_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full       = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.job   = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W + 1)'(1);
        2'b01:   fill <= fill - (QPTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hdl/atapio_back.sv
// ----------------------------------------------------------------------------
// atapio_back
// Expands queued jobs into result transactions, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module atapio_back import atapio_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  head_t       head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // port[2:0], value[18:3], fail_reason[21:19], zero[23:22]
  output logic [2:0]  m_tuser,   // action[2:0]
  output logic        m_tlast
);

  function automatic step_t tail_step(input tail_t tail);
    step_t s;
    unique case (tail)
      TAIL_CHUNK:  s = ST_CNT;
      TAIL_STATUS: s = ST_STAT;
      TAIL_DONE:   s = ST_DONE;
      TAIL_FAIL:   s = ST_FAIL;
      default:     s = ST_END;
    endcase
    return s;
  endfunction

  function automatic step_t first_step(input job_t job);
    step_t s;
    priority if (job.has_sel) s = ST_SEL;
    else if (job.has_word)    s = ST_WORD;
    else                      s = tail_step(job.tail);
    return s;
  endfunction

  logic       started;
  step_t      step, cur_step, step_next;
  logic       advance;
  logic [2:0] res_action;
  logic [2:0] res_port;
  logic [15:0] res_value;
  logic [2:0] res_reason;
  logic [7:0] dev_byte;

  assign cur_step = started ? step : first_step(head.job);
  assign advance  = head.valid && (!m_tvalid || m_tready);
  assign pop      = advance && (step_next == ST_END);
  assign dev_byte = DEV_BASE | (head.job.drive ? DEV_SLAVE : 8'h00);

  // Next step
  always_comb begin
    unique case (cur_step)
      ST_SEL:  step_next = ST_CNT;
      ST_WORD: step_next = tail_step(head.job.tail);
      ST_CNT:  step_next = ST_L0;
      ST_L0:   step_next = ST_L1;
      ST_L1:   step_next = ST_L2;
      ST_L2:   step_next = ST_DEV;
      ST_DEV:  step_next = ST_CMD;
      ST_CMD:  step_next = ST_STAT;
      default: step_next = ST_END;
    endcase
  end

  // Result fields of the current step
  always_comb begin
    res_action = ACT_REG;
    res_port   = PORT_DATA;
    res_value  = '0;
    res_reason = RSN_NONE;
    unique case (cur_step)
      ST_SEL: begin
        res_port  = PORT_DEVICE;
        res_value = 16'(dev_byte);
      end
      ST_WORD: begin
        res_action = head.job.direction ? ACT_WRDATA : ACT_TOHOST;
        res_value  = head.job.word;
      end
      ST_CNT: begin
        res_port  = PORT_COUNT;
        res_value = 16'(head.job.count_byte);
      end
      ST_L0: begin
        res_port  = PORT_LBA0;
        res_value = 16'(head.job.lba[7:0]);
      end
      ST_L1: begin
        res_port  = PORT_LBA1;
        res_value = 16'(head.job.lba[15:8]);
      end
      ST_L2: begin
        res_port  = PORT_LBA2;
        res_value = 16'(head.job.lba[23:16]);
      end
      ST_DEV: begin
        res_port  = PORT_DEVICE;
        res_value = 16'(dev_byte | {4'h0, head.job.lba[27:24]});
      end
      ST_CMD: begin
        res_port  = PORT_COMMAND;
        res_value = 16'(head.job.direction ? CMD_WRITE : CMD_READ);
      end
      ST_STAT: begin
        res_action = ACT_STATUS;
        res_port   = PORT_COMMAND;
      end
      ST_DONE: begin
        res_action = ACT_DONE;
      end
      ST_FAIL: begin
        res_action = ACT_FAIL;
        res_reason = head.job.reason;
      end
      default: begin
        res_action = ACT_REG;
      end
    endcase
  end

  // Track the step within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      step    <= ST_END;
    end else if (advance) begin
      started <= !pop;
      step    <= step_next;
    end
  end

  // Hold each result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= res_action;
      m_tdata <= {2'b00, res_reason, res_value, res_port};
      m_tlast <= pop;
    end
  end

endmodule

>>> hdl/ata_pio_transfer_sequencer.sv
// Path: an accepted item is stored in the job queue, and its first result is registered onto m_tvalid.
// Throughput: one input item per cycle; the back end emits one result per cycle while m_tready
// takes them, and an item causes at most 8 results, with a 4-job queue in between;
// input stalls only while that queue is full.
// Status items accepted in the status phase with DRQ set (and BSY clear) produce no result.
// Reset: synchronous rst clears phase, transfer state and queue; highest_lba to 163839.
// ----------------------------------------------------------------------------
// ata_pio_transfer_sequencer
// Host-side ATA PIO LBA28 sector transfer sequencer: front classifier, job
// queue and result expander.
// ----------------------------------------------------------------------------
module ata_pio_transfer_sequencer import atapio_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // is_write[0], drive[1], lba[29:2], sector_count[45:30], status_byte[53:46],
  // data_word[69:54], zero[71:70]
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // port[2:0], value[18:3], fail_reason[21:19], zero[23:22]
  output logic [2:0]  m_tuser,   // action[2:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_data
);

  logic  accept;
  logic  push;
  job_t  push_job;
  logic  pop;
  logic  full;
  head_t head;

  assign s_tready  = !full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  atapio_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (s_tuser),
    .is_write     (s_tdata[0]),
    .drive        (s_tdata[1]),
    .lba          (s_tdata[29:2]),
    .sector_count (s_tdata[45:30]),
    .status_byte  (s_tdata[53:46]),
    .data_word    (s_tdata[69:54]),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_value    (cfg_data),
    .push         (push),
    .push_job     (push_job)
  );

  atapio_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .head     (head)
  );

  atapio_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hdl/atapio_checker.sv
// ----------------------------------------------------------------------------
// atapio_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ata_pio_transfer_sequencer_assert.svh"

module atapio_checker import atapio_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // Hold a stalled result
  `ATAPIO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // Done, failed and status read always end the item's results
  `ATAPIO_ASSERT_SAME(a_end_last, m_tvalid && (m_tuser == ACT_DONE || m_tuser == ACT_FAIL || m_tuser == ACT_STATUS), m_tlast, "closing result without last")

  // A register write is always followed by more results of the same item
  `ATAPIO_ASSERT_SAME(a_reg_not_last, m_tvalid && m_tuser == ACT_REG, !m_tlast, "register write marked last")

  // Only failed results carry a reason
  `ATAPIO_ASSERT_SAME(a_reason_fail, m_tvalid && m_tuser != ACT_FAIL, m_tdata[21:19] == RSN_NONE, "reason on non-failed result")

endmodule

bind ata_pio_transfer_sequencer atapio_checker u_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: ATA PIO transfer sequencer testbench
// Streams start, status and data transactions into the sequencer and predicts
// every task-file action with a cycle-free shadow of the transfer state. Each
// result transaction is checked field by field against the oldest prediction.
// Covers range and zero-count faults, busy polling, missing DRQ, chunk setup
// at several limits, data streaming under back-pressure, and stray items.
// ----------------------------------------------------------------------------
module tb_top;
  import atapio_pkg::*;

  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [27:0] LBA_TOP     = 28'hFFFFFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic        is_write;
    logic        drive;
    logic [27:0] lba;
    logic [15:0] count;
    logic [7:0]  status;
    logic [15:0] word;
    logic        drain_first;  // hold off until every prediction has arrived
  } host_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  port;
    logic [15:0] value;
    logic [2:0]  reason;
    logic        last;
  } bus_action_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [27:0] cfg_data = '0;

  ata_pio_transfer_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  host_item_t  host_items[$];
  bus_action_t expected_actions[$];
  bus_action_t step_out[$];
  host_item_t  offered_item;
  bit          offer_taken = 1'b0;
  int          n_accepted = 0;
  int          items_queued = 0;
  int          mismatches = 0;
  int          holds_asked = 0;

  // Shadow of the sequencer state
  phase_t      shadow_phase;
  logic        shadow_dir;
  logic        shadow_drive;
  logic [27:0] shadow_lba;
  logic        shadow_over;
  logic [15:0] shadow_sectors;
  logic [16:0] shadow_words;
  logic [27:0] shadow_highest;

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("MISMATCH at %0t ns: %s (expected 0x%0h, got 0x%0h)", $time, what, want, got);
    mismatches++;
  endtask

  function automatic void add_action(input logic [2:0] act, input logic [2:0] prt,
                                     input logic [15:0] val, input logic [2:0] rsn);
    bus_action_t a;
    a.action = act;
    a.port   = prt;
    a.value  = val;
    a.reason = rsn;
    a.last   = 1'b0;
    step_out.push_back(a);
  endfunction

  function automatic void abort_transfer(input logic [2:0] rsn);
    shadow_phase = PH_IDLE;
    add_action(ACT_FAIL, PORT_DATA, 16'h0000, rsn);
  endfunction

  function automatic logic [7:0] device_byte();
    return DEV_BASE | (shadow_drive ? DEV_SLAVE : 8'h00);
  endfunction

  // Emit the task-file writes of the next chunk, or fail if it starts out of range
  function automatic void issue_next_chunk();
    logic [8:0]  chunk;
    logic [28:0] sum;
    if (shadow_over || shadow_lba > shadow_highest) begin
      abort_transfer(RSN_LBA);
      return;
    end
    chunk = (shadow_sectors >= 16'd256) ? 9'd256 : shadow_sectors[8:0];
    add_action(ACT_REG, PORT_COUNT, {8'h00, chunk[7:0]}, RSN_NONE);
    add_action(ACT_REG, PORT_LBA0, {8'h00, shadow_lba[7:0]}, RSN_NONE);
    add_action(ACT_REG, PORT_LBA1, {8'h00, shadow_lba[15:8]}, RSN_NONE);
    add_action(ACT_REG, PORT_LBA2, {8'h00, shadow_lba[23:16]}, RSN_NONE);
    add_action(ACT_REG, PORT_DEVICE, {8'h00, device_byte() | {4'h0, shadow_lba[27:24]}},
               RSN_NONE);
    add_action(ACT_REG, PORT_COMMAND, {8'h00, shadow_dir ? CMD_WRITE : CMD_READ}, RSN_NONE);
    add_action(ACT_STATUS, PORT_COMMAND, 16'h0000, RSN_NONE);
    sum = {1'b0, shadow_lba} + {20'h0, chunk};
    if (sum[28]) shadow_over = 1'b1;
    shadow_lba     = sum[27:0];
    shadow_sectors = shadow_sectors - {7'h0, chunk};
    shadow_words   = {chunk, 8'h00};
    shadow_phase   = PH_STATUS;
  endfunction

  // Work out the actions caused by one accepted transaction
  function automatic void predict_actions(input host_item_t it);
    bus_action_t tail;
    step_out.delete();
    if (it.mode == MODE_START && shadow_phase == PH_IDLE) begin
      if (it.lba > shadow_highest) begin
        abort_transfer(RSN_LBA);
      end else if (it.count == 16'd0) begin
        abort_transfer(RSN_ZERO);
      end else begin
        shadow_dir     = it.is_write;
        shadow_drive   = it.drive;
        shadow_lba     = it.lba;
        shadow_over    = 1'b0;
        shadow_sectors = it.count;
        add_action(ACT_REG, PORT_DEVICE, {8'h00, device_byte()}, RSN_NONE);
        issue_next_chunk();
      end
    end else if (it.mode == MODE_STATUS && shadow_phase == PH_STATUS) begin
      if (it.status[STATUS_BSY_BIT]) begin
        add_action(ACT_STATUS, PORT_COMMAND, 16'h0000, RSN_NONE);
      end else if (!it.status[STATUS_DRQ_BIT]) begin
        abort_transfer(RSN_NODRQ);
      end else begin
        shadow_phase = PH_DATA;
      end
    end else if (it.mode == MODE_DATA && shadow_phase == PH_DATA) begin
      add_action(shadow_dir ? ACT_WRDATA : ACT_TOHOST, PORT_DATA, it.word, RSN_NONE);
      if (shadow_words != 17'd0) shadow_words = shadow_words - 17'd1;
      if (shadow_words == 17'd0) begin
        if (shadow_sectors == 16'd0) begin
          shadow_phase = PH_IDLE;
          add_action(ACT_DONE, PORT_DATA, 16'h0000, RSN_NONE);
        end else begin
          issue_next_chunk();
        end
      end
    end else begin
      abort_transfer(RSN_UNEXPECTED);
    end
    if (step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
    end
    foreach (step_out[i]) expected_actions.push_back(step_out[i]);
  endfunction

  // Record accepted input transactions and advance the shadow
  always @(posedge clk) begin
    if (rst) begin
      shadow_phase   = PH_IDLE;
      shadow_dir     = 1'b0;
      shadow_drive   = 1'b0;
      shadow_lba     = '0;
      shadow_over    = 1'b0;
      shadow_sectors = '0;
      shadow_words   = '0;
      shadow_highest = HIGHEST_LBA_RESET;
    end else if (s_tvalid && s_tready) begin
      predict_actions(offered_item);
      offer_taken = 1'b1;
      n_accepted++;
    end
  end

  // Drive input transactions in bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    host_item_t nxt;
    bit send;
    if (!rst && (!s_tvalid || offer_taken)) begin
      send = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (host_items.size() > 0 &&
                   !(host_items[0].drain_first && expected_actions.size() != 0)) begin
        nxt  = host_items.pop_front();
        send = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      s_tvalid <= send;
      if (send) begin
        offered_item = nxt;
        s_tdata <= {2'b00, nxt.word, nxt.status, nxt.count, nxt.lba, nxt.drive, nxt.is_write};
        s_tuser <= nxt.mode;
      end
    end
    offer_taken = 1'b0;
  end

  // Stall the result side on a changing pattern; serve long hold-off requests
  int rx_cyc = 0;
  int rx_style = 0;
  int hold_left = 0;
  int holds_done = 0;
  always @(negedge clk) begin
    bit rdy;
    rx_cyc++;
    if (holds_done != holds_asked) begin
      hold_left  = 400;
      holds_done = holds_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (rx_cyc % 64 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0: rdy = 1'b1;
        1: rdy = (rx_cyc % 4) != 3;
        2: rdy = $urandom_range(0, 1);
        default: rdy = (rx_cyc % 8) < 2;
      endcase
    end
    m_tready <= rdy;
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    bus_action_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_actions.size() == 0) begin
        note_mismatch("result with no prediction waiting, action", 0, m_tuser);
      end else begin
        want = expected_actions.pop_front();
        if (m_tuser != want.action) note_mismatch("action", want.action, m_tuser);
        if (m_tdata[2:0] != want.port) note_mismatch("port", want.port, m_tdata[2:0]);
        if (m_tdata[18:3] != want.value) note_mismatch("value", want.value, m_tdata[18:3]);
        if (m_tdata[21:19] != want.reason)
          note_mismatch("fail_reason", want.reason, m_tdata[21:19]);
        if (m_tlast != want.last) note_mismatch("last", want.last, m_tlast);
      end
    end
  end

  task automatic push_item(input logic [1:0] m, input logic wr, input logic drv,
                           input logic [27:0] lba, input logic [15:0] cnt,
                           input logic [7:0] st, input logic [15:0] wd, input logic drain);
    host_item_t it;
    it.mode = m;
    it.is_write = wr;
    it.drive = drv;
    it.lba = lba;
    it.count = cnt;
    it.status = st;
    it.word = wd;
    it.drain_first = drain;
    host_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_start(input logic wr, input logic drv, input logic [27:0] lba,
                            input logic [15:0] cnt);
    push_item(MODE_START, wr, drv, lba, cnt, 8'($urandom), 16'($urandom), 1'b0);
  endtask

  task automatic push_status(input logic [7:0] st, input logic drain);
    push_item(MODE_STATUS, 1'($urandom), 1'($urandom), 28'($urandom), 16'($urandom),
              st, 16'($urandom), drain);
  endtask

  task automatic push_data(input logic [15:0] wd);
    push_item(MODE_DATA, 1'($urandom), 1'($urandom), 28'($urandom), 16'($urandom),
              8'($urandom), wd, 1'b0);
  endtask

  task automatic push_words(input int n);
    repeat (n) push_data(16'($urandom));
  endtask

  task automatic push_junk(input logic [1:0] m);
    push_item(m, 1'($urandom), 1'($urandom), 28'($urandom), 16'($urandom),
              8'($urandom), 16'($urandom), 1'b0);
  endtask

  // Wait until the sender is empty and every prediction has been matched
  task automatic settle();
    while (host_items.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_highest(input logic [27:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_highest = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One transfer with random content; unless it fails early, a stray item cuts it short
  task automatic queue_random_transfer();
    logic        wr;
    logic        drv;
    logic [27:0] lba;
    logic [15:0] cnt;
    int          pick;
    logic [1:0]  stray;
    wr  = 1'($urandom);
    drv = 1'($urandom);
    if ($urandom_range(0, 9) == 0 && shadow_highest != LBA_TOP)
      lba = 28'($urandom_range(shadow_highest + 1, LBA_TOP));
    else
      lba = 28'($urandom_range(0, shadow_highest));
    pick = $urandom_range(0, 9);
    cnt  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 2));
    push_item(MODE_START, wr, drv, lba, cnt, 8'($urandom), 16'($urandom),
              $urandom_range(0, 19) == 0);
    if (lba > shadow_highest || cnt == 16'd0) return;
    repeat ($urandom_range(0, 2)) push_status(8'h80 | 8'($urandom), 1'b0);
    if ($urandom_range(0, 9) == 0) begin
      push_status(8'($urandom) & 8'h77, 1'b0);
      return;
    end
    push_status((8'($urandom) & 8'h7F) | 8'h08, $urandom_range(0, 19) == 0);
    push_words($urandom_range(0, 12));
    stray = 2'($urandom_range(0, 2));
    if (stray == MODE_DATA) stray = MODE_UNUSED;
    push_junk(stray);
  endtask

  task automatic run_random_phase(input logic [27:0] limit);
    int base;
    write_highest(limit);
    base = items_queued;
    while (items_queued - base < 15) queue_random_transfer();
    settle();
  endtask

  initial begin
    int base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Faults and short transfers under the reset limit
    push_start(1'b0, 1'b0, 28'd163840, 16'd5);
    push_start(1'b0, 1'b0, LBA_TOP, 16'd0);
    push_start(1'b1, 1'b1, 28'd0, 16'd0);
    push_junk(MODE_STATUS);
    push_junk(MODE_DATA);
    push_junk(MODE_UNUSED);
    push_start(1'b1, 1'b1, 28'd163839, 16'd1);
    push_status(8'h80, 1'b0);
    push_status(8'hFF, 1'b1);
    push_status(8'h08, 1'b0);
    push_data(16'h0000);
    push_data(16'hFFFF);
    push_words(4);
    push_junk(MODE_UNUSED);
    push_start(1'b0, 1'b0, 28'd0, 16'd2);
    push_status(8'h00, 1'b0);
    push_start(1'b0, 1'b1, 28'd5, 16'd1);
    push_junk(MODE_START);
    push_start(1'b0, 1'b1, 28'd5, 16'd1);
    push_status(8'h77, 1'b0);
    push_start(1'b0, 1'b0, 28'd0, 16'hFFFF);
    push_junk(MODE_DATA);
    push_start(1'b0, 1'b0, 28'd77, 16'd1);
    push_status(8'h7F, 1'b0);
    push_words(3);
    push_junk(MODE_START);
    push_start(1'b1, 1'b0, 28'd0, 16'hFFFF);
    push_status(8'h08, 1'b0);
    push_words(2);
    push_junk(MODE_STATUS);
    settle();

    // Lowest limit: only sector zero may start
    write_highest(28'd0);
    push_start(1'b0, 1'b1, 28'd1, 16'd1);
    push_start(1'b0, 1'b1, 28'd0, 16'd1);
    push_status(8'h08, 1'b0);
    push_words(4);
    push_junk(MODE_UNUSED);
    settle();

    // Highest limit: a long word stream, then a start at the top sector
    write_highest(LBA_TOP);
    base = n_accepted;
    push_start(1'b1, 1'b0, LBA_TOP - 28'd100, 16'd257);
    push_status(8'h88, 1'b0);
    push_status(8'h08, 1'b0);
    push_words(40);
    push_junk(MODE_START);
    push_start(1'b0, 1'b1, LBA_TOP, 16'd1);
    push_status(8'h08, 1'b0);
    push_words(3);
    push_junk(MODE_STATUS);
    // Hold the result side off mid-stream so the input backs up
    while (n_accepted < base + 12) @(posedge clk);
    holds_asked++;
    settle();

    // Mid-range limit
    write_highest(28'd1000);
    push_start(1'b1, 1'b1, 28'd1001, 16'd3);
    push_start(1'b1, 1'b1, 28'd900, 16'd257);
    push_status(8'h08, 1'b0);
    push_words(5);
    push_junk(MODE_UNUSED);
    settle();

    run_random_phase(28'($urandom));
    run_random_phase(28'($urandom_range(0, 5000)));
    run_random_phase(HIGHEST_LBA_RESET);
    run_random_phase(LBA_TOP);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #100000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
